// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the erosion block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while rst_n is low.
`define BEC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("erosion block: implication check failed");

// Next-cycle implication, checked on clk, disabled while rst_n is low.
`define BEC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("erosion block: next-cycle check failed");

`endif

// ===== hw/rtl/bec_pkg.sv =====
// Types and constants of the cross-shaped binary erosion block.
`default_nettype none

package bec_pkg;

  localparam int FRAME_WIDTH_W  = 9;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 12;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 9'd160;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd120;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // One column of the two-row line store: upper row bit and centre row bit.
  typedef struct packed {
    logic upper;
    logic centre;
  } col_pair_t;

  typedef struct packed {
    logic eroded;
    logic frame_end;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_erosion_cross.sv =====
// Top level of the cross-shaped binary erosion block.
`default_nettype none
`include "assert_macros.svh"

// Streaming 3x3 cross erosion of a binary mask in raster order. One pixel is
// accepted per clock cycle while the output skid slot is free: the two-row
// line store is a circular chain of MAX_WIDTH one-column cells that all
// shift together on each accepted pixel, with the loop closed at the cell
// chosen by frame_width. Result pixel (r,c)
// leaves one row behind the input, when pixel (r+1,c) is accepted; the first
// row of each frame gives no results, and after the frame_height rows the
// source sends one padding row (values ignored) that flushes the last row,
// whose final pixel carries out_frame_end. Border pixels always give 0.
// Results pass through an output register with a skid slot, so input keeps
// flowing while one result waits. Write frame_width and frame_height only
// between frames, when no request is in flight.
module binary_erosion_cross #(
  parameter int MAX_WIDTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_eroded,
  output logic                                      out_frame_end,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bec_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [bec_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = (CIW + 1 > bec_pkg::FRAME_WIDTH_W) ? CIW + 1
                                                          : bec_pkg::FRAME_WIDTH_W;
  localparam int HW  = bec_pkg::FRAME_HEIGHT_W;

  logic [bec_pkg::FRAME_WIDTH_W-1:0] frame_width_r, frame_width_nxt;
  logic [HW-1:0]                     frame_height_r, frame_height_nxt;
  logic [CIW-1:0]                    col_r, col_nxt;
  logic [HW-1:0]                     row_r, row_nxt;
  logic                              centre_pixel_r, centre_pixel_nxt;

  logic [WW-1:0]  fw_ext, w_eff, col_ext, c_ext;
  logic [HW-1:0]  h_eff, rw;
  logic [CIW-1:0] c;
  logic           accept, last_col, px, emit, e_ok;
  logic           skid_ready;

  bec_pkg::col_pair_t cell_q  [MAX_WIDTH];
  bec_pkg::col_pair_t head_in;
  bec_pkg::result_t   res, out_data;

  assign cfg_ready = 1'b1;

  // Effective frame size: zero acts as one, width clamps to the store depth.
  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (fw_ext == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (frame_height_r == '0) ? HW'(1) : frame_height_r;
  end

  // Position of this pixel; restart positions left beyond the frame size.
  always_comb begin
    col_ext  = WW'(col_r);
    c        = (col_ext >= w_eff) ? '0 : col_r;
    c_ext    = WW'(c);
    rw       = (row_r > h_eff) ? '0 : row_r;
    last_col = (c_ext + WW'(1)) >= w_eff;
    px       = (rw < h_eff) ? in_pixel : 1'b0;
    emit     = (rw != '0);
    e_ok     = (rw >= HW'(2)) && (rw < h_eff) && (c != '0) && !last_col;
  end

  assign in_ready = skid_ready;
  assign accept   = in_valid && in_ready;

  // Cell 0 holds the current column, cell 1 the one to its right.
  always_comb begin
    res.eroded    = e_ok & cell_q[0].upper & cell_q[0].centre & cell_q[1].centre
                    & centre_pixel_r & px;
    res.frame_end = (rw == h_eff) && last_col;
    head_in.upper  = cell_q[0].centre;
    head_in.centre = px;
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    bec_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .tail     (w_eff == WW'(k + 1)),
      .head_in  (head_in),
      .next_in  ((k == MAX_WIDTH - 1) ? head_in : cell_q[(k + 1) % MAX_WIDTH]),
      .q        (cell_q[k])
    );
  end

  always_comb begin
    col_nxt          = col_r;
    row_nxt          = row_r;
    centre_pixel_nxt = centre_pixel_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (accept) begin
      centre_pixel_nxt = cell_q[0].centre;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = (rw >= h_eff) ? '0 : rw + HW'(1);
      end else begin
        col_nxt = c + CIW'(1);
        row_nxt = rw;
      end
    end
    if (cfg_valid) begin
      case (bec_pkg::cfg_reg_t'(cfg_index))
        bec_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[bec_pkg::FRAME_WIDTH_W-1:0];
        bec_pkg::REG_FRAME_HEIGHT: frame_height_nxt = cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bec_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bec_pkg::FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      centre_pixel_r <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      centre_pixel_r <= centre_pixel_nxt;
    end
  end

  bec_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && emit),
    .push_data  (res),
    .push_ready (skid_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_eroded    = out_data.eroded;
  assign out_frame_end = out_data.frame_end;

  // The last pixel of a frame sits on the bottom-right border.
  `BEC_ASSERT_IMP(a_frame_end_is_border, out_valid && out_frame_end, !out_eroded)

endmodule

`default_nettype wire

// ===== hw/rtl/bec_cell.sv =====
// One line-store cell: holds one column of the upper and centre rows.
`default_nettype none

module bec_cell (
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic              tail,
  input  wire bec_pkg::col_pair_t head_in,
  input  wire bec_pkg::col_pair_t next_in,
  output bec_pkg::col_pair_t     q
);

  bec_pkg::col_pair_t q_r;
  bec_pkg::col_pair_t q_nxt;

  // The tail cell closes the loop and takes the freshly written column.
  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = tail ? head_in : next_in;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bec_skid.sv =====
// Two-entry output register with skid stage for the result channel.
`default_nettype none
`include "assert_macros.svh"

module bec_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bec_pkg::result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bec_pkg::result_t     out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  bec_pkg::result_t  main_r, main_nxt;
  bec_pkg::result_t  skid_r, skid_nxt;
  logic              pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // advance the held request once the main slot drains
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  `BEC_ASSERT_IMP(a_skid_behind_main, skid_valid_r, main_valid_r)
  `BEC_ASSERT_NXT(a_skid_holds_on_stall, skid_valid_r && !out_ready, skid_valid_r)

endmodule

`default_nettype wire

// ===== verif/binary_erosion_cross_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_erosion_cross: directed and random frames against a line-store predictor.
`default_nettype none

module binary_erosion_cross_tb;
  import bec_pkg::*;

  localparam int unsigned LINE_DEPTH    = 256;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_pixel;
  logic out_valid;
  logic out_ready;
  logic out_eroded;
  logic out_frame_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Pixels waiting to be sent, and eroded pixels still owed by the block.
  logic pixel_q[$];
  result_t eroded_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit pixel_taken = 1'b0;

  // Predictor state: two line stores, raster position, 3-pixel window of the centre row.
  bit upper_line [LINE_DEPTH];
  bit centre_line [LINE_DEPTH];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  bit left_px = 1'b0;
  bit mid_px = 1'b0;
  logic [FRAME_WIDTH_W-1:0] mask_width = FRAME_WIDTH_RST;
  logic [FRAME_HEIGHT_W-1:0] mask_height = FRAME_HEIGHT_RST;

  binary_erosion_cross #(
    .MAX_WIDTH(LINE_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_eroded   (out_eroded),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned width_in_use();
    if (mask_width == 0) return 1;
    if (mask_width > LINE_DEPTH) return LINE_DEPTH;
    return mask_width;
  endfunction

  function automatic int unsigned height_in_use();
    return (mask_height == 0) ? 1 : mask_height;
  endfunction

  // Advance the predictor by one accepted pixel; owe a result from the second row on.
  function automatic void erode_step(input logic pixel);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit px;
    bit up;
    bit right;
    bit e;
    w = width_in_use();
    h = height_in_use();
    if (col_pos >= w) col_pos = 0;
    if (row_pos > h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    // drop the pixel value in the padding row
    px = (r < h) ? pixel : 1'b0;
    left_px = mid_px;
    mid_px = centre_line[c];
    up = upper_line[c];
    right = (c + 1 < w) ? centre_line[c + 1] : 1'b0;
    if (r >= 1) begin
      // result row is r-1; every border pixel stays clear
      e = (r > 1 && r < h && c > 0 && c + 1 < w) ? (up & px & left_px & right & mid_px) : 1'b0;
      eroded_q.push_back('{eroded: e, frame_end: (r == h && c == w - 1)});
    end
    upper_line[c] = centre_line[c];
    centre_line[c] = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Hold a register write until the block takes it; the caller lowers cfg_valid.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH: mask_width = data[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: mask_height = data[FRAME_HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || eroded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram the frame size once idle, then queue one frame plus its padding row.
  task automatic run_frame(input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data,
                           input int unsigned ones_pct, input bit stray,
                           output int unsigned n_items);
    int unsigned w_eff;
    int unsigned h_eff;
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, w_data);
    if (stray) cfg_write(REG_UNUSED, $urandom);
    cfg_write(REG_FRAME_HEIGHT, h_data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    w_eff = width_in_use();
    h_eff = height_in_use();
    for (int r = 0; r <= h_eff; r++) begin
      for (int c = 0; c < w_eff; c++) begin
        if (r < h_eff) pixel_q.push_back($urandom_range(99) < ones_pct);
        else pixel_q.push_back($urandom_range(1));
      end
    end
    n_items = w_eff * (h_eff + 1);
  endtask

  task automatic random_phase(input int unsigned item_goal, input logic [CFG_DATA_W-1:0] big_w,
                              input logic [CFG_DATA_W-1:0] big_h);
    int unsigned items;
    int unsigned n;
    int unsigned ones_pct;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    items = 0;
    run_frame(big_w, big_h, 90, 1'b0, n);
    while (items < item_goal) begin
      w_data = ($urandom_range(99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 40);
      // set the unused upper bits now and then
      if ($urandom_range(9) == 0) w_data[CFG_DATA_W-1:FRAME_WIDTH_W] = $urandom_range(1, 7);
      h_data = $urandom_range(0, 12);
      case ($urandom_range(3))
        0: ones_pct = 45;
        1: ones_pct = 80;
        2: ones_pct = 95;
        default: ones_pct = 100;
      endcase
      run_frame(w_data, h_data, ones_pct, $urandom_range(7) == 0, n);
      items += n;
    end
  endtask

  // Record an accepted pixel request.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      erode_step(in_pixel);
      pixel_taken = 1'b1;
    end
  end

  // Present the next pixel or idle; hold valid until the request is taken.
  always @(negedge clk) begin
    if (!in_valid || pixel_taken) begin
      pixel_taken = 1'b0;
      if (rst_n && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_pixel <= $urandom_range(1);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_eroded
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (eroded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got eroded=%0b frame_end=%0b",
                   $time, out_eroded, out_frame_end);
      end else begin
        want = eroded_q.pop_front();
        if (out_eroded !== want.eroded) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: eroded mismatch, expected %0b, got %0b",
                     $time, want.eroded, out_eroded);
        end
        if (out_frame_end !== want.frame_end) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: frame_end mismatch, expected %0b, got %0b",
                     $time, want.frame_end, out_frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL binary_erosion_cross");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    send_idle_pct = 11;
    recv_idle_pct = 72;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // solid 4x3 frame with a stray register write; 0x0 acting as 1x1; masked width bits
    run_frame(12'd4, 12'd3, 100, 1'b1, n);
    run_frame(12'd0, 12'd0, 100, 1'b0, n);
    run_frame(12'hE03, 12'd1, 100, 1'b0, n);

    random_phase(480, 12'd256, 12'd2);
    send_idle_pct = 72;
    recv_idle_pct = 11;
    random_phase(480, 12'd1, 12'd4095);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(480, 12'd511, 12'd1);

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS binary_erosion_cross");
    end else begin
      $display("FAIL binary_erosion_cross");
    end
    $finish;
  end

endmodule

`default_nettype wire
